// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lepf_pkg.sv =====
// Package: widths, constants and shared types of the lane edge point finder.
`timescale 1ns / 1ps
package lepf_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int RUN_W   = 11;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 10;
    localparam int ENTRY_W = RUN_W + 1;
    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam int FW_W       = 12;
    localparam int FH_W       = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd1280;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 11'd720;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = ROW_W + 1 + COL_W + 1 + COL_W + COL_W + COL_W;

    // Per-word control decoded from the position counters and handshake.
    typedef struct packed {
        logic adv;        // a word is accepted this cycle
        logic meas;       // accepted word is a measure-pass word
        logic srch;       // accepted word is a search-pass word
        logic last_col;   // word closes its row
        logic last_row;   // word lies in the top row
        logic first_row;  // word lies in the bottom row
    } ctl_t;

endpackage

// ===== rtl/lane_edge_point_finder.sv =====
// Top level of the lane edge point finder: counters, handshake, config, wiring.
//
// Usage: stream a binary mask frame twice, one pixel per word, bottom row
// first and left to right in a row. s_tdata[0] is the pixel, s_tuser the
// pass: 0 measures the bottom-up run of set pixels per column and, on the
// top row, picks the base column of the left and right halves; 1 searches
// each row for the left and right edge points around those bases.
// Throughput: one pixel word per clock, but for the last pixel of a row while
// the output register is stalled. Each pixel costs one read-modify-write of
// its column RAM entry; the next column is read ahead, so the RAM port sets the rate.
// Result: the result word of a search row appears on m_tvalid/m_tdata in the
// cycle after the last pixel of that row is accepted. Measure rows give none.
// Stall: results sit in one output register. While it is full and m_tready
// is low, s_tready stays high for every pixel but the last of a row.
// Reset: aresetn (sync, active low) clears counters, bases, edge state and
// the output valid flag and loads frame_width 1280 / frame_height 720. The
// column RAM is not cleared: the bottom row of a measure pass writes every
// column before any later row reads it, so no clearing pass is needed.
// Config: cfg_we/cfg_addr/cfg_wdata, index 0 frame_width, 1 frame_height; the user
// writes them only while the block is idle, which the block does not enforce; values are clamped to the sizes.
`timescale 1ns / 1ps
module lane_edge_point_finder #(
    parameter int MAX_WIDTH  = lepf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lepf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [lepf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lepf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // pixel words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lepf_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] pixel, rest zero
    input  logic                              s_tuser,   // [0] mode
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lepf_pkg::M_TDATA_W-1:0]    m_tdata    // row, left_found, left_x,
                                                         // right_found, right_x,
                                                         // left_base, right_base
);
    import lepf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);        // column counter / RAM address
    localparam int WW = $clog2(MAX_WIDTH + 1);    // clamped width
    localparam int RW = $clog2(MAX_HEIGHT);       // row counter
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // clamped height

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          prev_pix_reg, prev_pix_next;

    logic [WW-1:0] w_use;
    logic [HW-1:0] h_use;
    logic          last_col, last_row;
    logic          accept, pix;
    ctl_t          ctl;
    logic [ROW_W-1:0] row_out;

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [COL_W-1:0]   best_left_col, best_right_col;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the frame size to what the counters and RAM support
    always_comb begin
        if (frame_width_reg < FW_W'(2)) begin
            w_use = WW'(2);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(frame_width_reg);
        end
        if (frame_height_reg < FH_W'(2)) begin
            h_use = HW'(2);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_use = HW'(MAX_HEIGHT);
        end else begin
            h_use = HW'(frame_height_reg);
        end
    end

    assign last_col = WW'(col_reg) >= (w_use - WW'(1));
    assign last_row = HW'(row_reg) >= (h_use - HW'(1));
    assign row_out  = last_row ? ROW_W'(0) : ROW_W'(h_use - HW'(1) - HW'(row_reg));

    // only the word that closes a row may need the output register
    assign s_tready = !m_tvalid || m_tready || !last_col;
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_tdata[0];

    always_comb begin
        ctl.adv       = accept;
        ctl.meas      = accept && !s_tuser;
        ctl.srch      = accept && s_tuser;
        ctl.last_col  = last_col;
        ctl.last_row  = last_row;
        ctl.first_row = (row_reg == '0);
    end

    // position counters advance on every word, whatever the pass
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        prev_pix_next = prev_pix_reg;
        if (accept) begin
            if (last_col) begin
                col_next      = '0;
                prev_pix_next = 1'b0;
                row_next      = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next      = col_reg + CW'(1);
                prev_pix_next = pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            prev_pix_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            prev_pix_reg <= prev_pix_next;
        end
    end

    // The RAM reads the column of the next word in the cycle before it. Successive
    // words always hit different columns, so a write never races the read
    // of the same entry and no forwarding is needed.
    lepf_col_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    lepf_measure #(
        .CW (CW),
        .WW (WW)
    ) u_measure (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .x              (col_reg),
        .mid            (w_use >> 1),
        .pix            (pix),
        .rdata          (ram_rdata),
        .we             (ram_we),
        .wdata          (ram_wdata),
        .best_left_col  (best_left_col),
        .best_right_col (best_right_col)
    );

    lepf_search #(
        .CW (CW)
    ) u_search (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .x              (col_reg),
        .pix            (pix),
        .prev_pix       (prev_pix_reg),
        .row_out        (row_out),
        .best_left_col  (best_left_col),
        .best_right_col (best_right_col),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// ===== rtl/lepf_col_ram.sv =====
// Column store: one run length and broken flag per column, registered read.
`timescale 1ns / 1ps
module lepf_col_ram #(
    parameter int DEPTH = lepf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [lepf_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [lepf_pkg::ENTRY_W-1:0] rdata
);
    import lepf_pkg::*;

    logic [ENTRY_W-1:0] col_mem_reg [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            col_mem_reg[waddr] <= wdata;
        end
        rdata_reg <= col_mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lepf_measure.sv =====
// Measure pass: column run update and base column tracking on the top row.
`timescale 1ns / 1ps
module lepf_measure #(
    parameter int CW = 11,
    parameter int WW = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lepf_pkg::ctl_t               ctl,
    input  logic [CW-1:0]                x,
    input  logic [WW-1:0]                mid,
    input  logic                         pix,
    input  logic [lepf_pkg::ENTRY_W-1:0] rdata,
    output logic                         we,
    output logic [lepf_pkg::ENTRY_W-1:0] wdata,
    output logic [lepf_pkg::COL_W-1:0]   best_left_col,
    output logic [lepf_pkg::COL_W-1:0]   best_right_col
);
    import lepf_pkg::*;

    logic [RUN_W-1:0] run_old, run_new;
    logic             broken_old, broken_new;
    logic             in_left;

    logic [RUN_W-1:0] best_left_len_reg, best_left_len_next;
    logic [RUN_W-1:0] best_right_len_reg, best_right_len_next;
    logic [COL_W-1:0] best_left_col_reg, best_left_col_next;
    logic [COL_W-1:0] best_right_col_reg, best_right_col_next;

    assign run_old    = rdata[RUN_W-1:0];
    assign broken_old = rdata[RUN_W];

    always_comb begin
        if (ctl.first_row) begin
            run_new    = RUN_W'(pix);
            broken_new = ~pix;
        end else if (!broken_old && pix) begin
            // saturating count of the unbroken run
            run_new    = (run_old < RUN_MAX) ? run_old + RUN_W'(1) : run_old;
            broken_new = 1'b0;
        end else begin
            run_new    = run_old;
            broken_new = 1'b1;
        end
    end

    assign we    = ctl.meas;
    assign wdata = {broken_new, run_new};

    assign in_left = WW'(x) < mid;

    always_comb begin
        best_left_len_next  = best_left_len_reg;
        best_left_col_next  = best_left_col_reg;
        best_right_len_next = best_right_len_reg;
        best_right_col_next = best_right_col_reg;
        if (ctl.meas && ctl.last_row) begin
            if (in_left) begin
                if (x == '0 || run_new > best_left_len_reg) begin
                    best_left_len_next = run_new;
                    best_left_col_next = COL_W'(x);
                end
            end else begin
                if (WW'(x) == mid || run_new > best_right_len_reg) begin
                    best_right_len_next = run_new;
                    best_right_col_next = COL_W'(x);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_left_len_reg  <= '0;
            best_left_col_reg  <= '0;
            best_right_len_reg <= '0;
            best_right_col_reg <= '0;
        end else begin
            best_left_len_reg  <= best_left_len_next;
            best_left_col_reg  <= best_left_col_next;
            best_right_len_reg <= best_right_len_next;
            best_right_col_reg <= best_right_col_next;
        end
    end

    assign best_left_col  = best_left_col_reg;
    assign best_right_col = best_right_col_reg;

endmodule

// ===== rtl/lepf_search.sv =====
// Search pass: edge detection along a row and the registered result word.
`timescale 1ns / 1ps
module lepf_search #(
    parameter int CW = 11
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lepf_pkg::ctl_t                   ctl,
    input  logic [CW-1:0]                    x,
    input  logic                             pix,
    input  logic                             prev_pix,
    input  logic [lepf_pkg::ROW_W-1:0]       row_out,
    input  logic [lepf_pkg::COL_W-1:0]       best_left_col,
    input  logic [lepf_pkg::COL_W-1:0]       best_right_col,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lepf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lepf_pkg::*;

    localparam int CMPW = (CW > COL_W) ? CW : COL_W;

    logic left_found_reg, left_found_next;
    logic right_found_reg, right_found_next;
    logic [COL_W-1:0] left_x_reg, left_x_next;
    logic [COL_W-1:0] right_x_reg, right_x_next;

    logic hit_l, hit_r;
    logic out_lf, out_rf;
    logic [COL_W-1:0] out_lx, out_rx;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 load;

    always_comb begin
        hit_l = ctl.srch && (x != '0) && (CMPW'(x) <= CMPW'(best_left_col))
                && pix && !prev_pix;
        hit_r = ctl.srch && (x != '0) && !right_found_reg
                && (CMPW'(x - CW'(1)) >= CMPW'(best_right_col)) && prev_pix && !pix;

        out_lf = left_found_reg | hit_l;
        out_lx = hit_l ? COL_W'(x) : left_x_reg;
        out_rf = right_found_reg | hit_r;
        out_rx = hit_r ? COL_W'(x - CW'(1)) : right_x_reg;

        left_found_next  = left_found_reg;
        left_x_next      = left_x_reg;
        right_found_next = right_found_reg;
        right_x_next     = right_x_reg;
        if (ctl.adv) begin
            if (ctl.last_col) begin
                left_found_next  = 1'b0;
                left_x_next      = '0;
                right_found_next = 1'b0;
                right_x_next     = '0;
            end else begin
                left_found_next  = out_lf;
                left_x_next      = out_lx;
                right_found_next = out_rf;
                right_x_next     = out_rx;
            end
        end
    end

    assign load = ctl.srch && ctl.last_col;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_found_reg  <= 1'b0;
            left_x_reg      <= '0;
            right_found_reg <= 1'b0;
            right_x_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            left_found_reg  <= left_found_next;
            left_x_reg      <= left_x_next;
            right_found_reg <= right_found_next;
            right_x_reg     <= right_x_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // fields from bit 0: row, left_found, left_x, right_found, right_x,
    // left_base, right_base; a column reads zero when its edge is absent
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= {best_right_col, best_left_col,
                           out_rf ? out_rx : COL_W'(0), out_rf,
                           out_lf ? out_lx : COL_W'(0), out_lf,
                           row_out};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/lepf_checker.sv =====
// Port-level checker for the lane edge point finder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lepf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lepf_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lepf_pkg::*;

    localparam int LF_BIT = ROW_W;
    localparam int LX_LO  = ROW_W + 1;
    localparam int RF_BIT = LX_LO + COL_W;
    localparam int RX_LO  = RF_BIT + 1;

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `ASSERT_CLK_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")
    `ASSERT_CLK(a_new_word, aclk, aresetn, m_tvalid && m_tready |=> !m_tvalid || $past(s_tvalid && s_tready), "result word without an accepted pixel")
    `ASSERT_CLK(a_left_zero, aclk, aresetn, m_tvalid && !m_tdata[LF_BIT] |-> m_tdata[LX_LO +: COL_W] == '0, "left_x nonzero without left edge")
    `ASSERT_CLK(a_right_zero, aclk, aresetn, m_tvalid && !m_tdata[RF_BIT] |-> m_tdata[RX_LO +: COL_W] == '0, "right_x nonzero without right edge")

endmodule

bind lane_edge_point_finder lepf_checker u_lepf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/lane_edge_point_finder_tb.sv =====
// Self-checking bench for the lane edge point finder: directed table, then random frames.
`timescale 1ns / 1ps
module lane_edge_point_finder_tb;

    localparam int MAX_W         = lepf_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H         = lepf_pkg::MAX_HEIGHT_DEF;
    localparam int RUN_LIMIT     = 2047;
    localparam int SETTLE_CYCLES = 4;     // margin after the last result word before a config write
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int RANDOM_ITEMS  = 900;

    localparam bit MODE_MEASURE = 1'b0;
    localparam bit MODE_SEARCH  = 1'b1;

    // Result word, row in the lowest bits.
    typedef struct packed {
        logic [lepf_pkg::COL_W-1:0] right_base;
        logic [lepf_pkg::COL_W-1:0] left_base;
        logic [lepf_pkg::COL_W-1:0] right_x;
        logic                       right_found;
        logic [lepf_pkg::COL_W-1:0] left_x;
        logic                       left_found;
        logic [lepf_pkg::ROW_W-1:0] row;
    } edge_word_t;

    typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_PIX_TYPED} step_kind_t;

    typedef struct packed {
        step_kind_t                      kind;
        logic [lepf_pkg::CFG_ADDR_W-1:0] addr;
        logic [lepf_pkg::CFG_DATA_W-1:0] value;
        logic                            mode;
        logic                            pix;
        edge_word_t                      want;
    } dir_step_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              cfg_we    = 1'b0;
    logic [lepf_pkg::CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [lepf_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [lepf_pkg::S_TDATA_W-1:0]    s_tdata  = '0;   // [0] pixel, rest zero
    logic                              s_tuser  = 1'b0; // [0] mode

    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [lepf_pkg::M_TDATA_W-1:0]    m_tdata;         // row, left_found, left_x,
                                                        // right_found, right_x,
                                                        // left_base, right_base

    lane_edge_point_finder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Edge tracker: own copy of the block state
    // ---------------------------------------------------------------
    int unsigned eff_w = lepf_pkg::FRAME_WIDTH_RST;
    int unsigned eff_h = lepf_pkg::FRAME_HEIGHT_RST;

    int unsigned col_run      [MAX_W];
    bit          col_broken   [MAX_W];
    bit          col_written  [MAX_W];   // entry filled by a bottom-row measure word
    int unsigned col_q        = 0;
    int unsigned row_q        = 0;
    bit          prev_q       = 1'b0;
    int unsigned best_l_len   = 0;
    int unsigned best_l_col   = 0;
    int unsigned best_r_len   = 0;
    int unsigned best_r_col   = 0;
    bit          lf_q         = 1'b0;
    int unsigned lx_q         = 0;
    bit          rf_q         = 1'b0;
    int unsigned rx_q         = 0;

    edge_word_t edge_words_due [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int pixels_sent  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    function automatic bit track_edges(input bit mode, input bit pix, output edge_word_t word);
        int unsigned x;
        int unsigned run;
        int unsigned mid;
        bit last_col;
        bit last_row;
        bit made;
        made     = 1'b0;
        word     = '0;
        x        = col_q;
        last_col = (x >= eff_w - 1);
        last_row = (row_q >= eff_h - 1);

        if (mode == MODE_MEASURE) begin
            if (row_q == 0) begin
                run             = pix;
                col_broken[x]   = !pix;
                col_written[x]  = 1'b1;
            end else if (!col_broken[x] && pix) begin
                run = col_run[x];
                if (run < RUN_LIMIT) run++;
            end else begin
                run           = col_run[x];
                col_broken[x] = 1'b1;
            end
            col_run[x] = run;

            // top row picks the bases, first column wins on a tie
            if (last_row) begin
                mid = eff_w / 2;
                if (x < mid) begin
                    if (x == 0 || run > best_l_len) begin
                        best_l_len = run;
                        best_l_col = x;
                    end
                end else if (x == mid || run > best_r_len) begin
                    best_r_len = run;
                    best_r_col = x;
                end
            end
        end else begin
            if (x >= 1) begin
                // left edge: last rising step at or left of the base
                if (x <= best_l_col && pix && !prev_q) begin
                    lf_q = 1'b1;
                    lx_q = x;
                end
                // right edge: first falling step at or right of the base
                if (!rf_q && x - 1 >= best_r_col && prev_q && !pix) begin
                    rf_q = 1'b1;
                    rx_q = x - 1;
                end
            end
            if (last_col) begin
                word.row         = 10'(last_row ? 0 : eff_h - 1 - row_q);
                word.left_found  = lf_q;
                word.left_x      = lf_q ? 11'(lx_q) : '0;
                word.right_found = rf_q;
                word.right_x     = rf_q ? 11'(rx_q) : '0;
                word.left_base   = 11'(best_l_col);
                word.right_base  = 11'(best_r_col);
                made             = 1'b1;
            end
        end

        prev_q = pix;
        if (last_col) begin
            col_q  = 0;
            prev_q = 1'b0;
            lf_q   = 1'b0;
            lx_q   = 0;
            rf_q   = 1'b0;
            rx_q   = 0;
            if (last_row) row_q = 0;
            else row_q++;
        end else begin
            col_q++;
        end
        return made;
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    task automatic push_pixel(input bit mode, input bit pix);
        edge_word_t word;
        bit m;
        m = mode;
        // never let a measure word read a column entry that was never filled
        if (m == MODE_MEASURE && row_q != 0 && !col_written[col_q]) m = MODE_SEARCH;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {{(lepf_pkg::S_TDATA_W-1){1'b0}}, pix};
        do @(posedge aclk); while (!s_tready);
        if (track_edges(m, pix, word)) edge_words_due = {edge_words_due, word};
        pixels_sent++;
    endtask

    // Registers only move while the block is idle.
    task automatic write_reg(input logic [lepf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [lepf_pkg::CFG_DATA_W-1:0] value);
        int unsigned v;
        s_tvalid <= 1'b0;
        while (edge_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (addr == lepf_pkg::REG_FRAME_WIDTH) begin
            v     = value;
            eff_w = (v < 2) ? 2 : (v > MAX_W) ? MAX_W : v;
        end else begin
            v     = value[lepf_pkg::FH_W-1:0];
            eff_h = (v < 2) ? 2 : (v > MAX_H) ? MAX_H : v;
        end
    endtask

    // Search words until the counters sit at the start of a frame.
    task automatic align_frame();
        while (col_q != 0 || row_q != 0) push_pixel(MODE_SEARCH, 1'($urandom_range(1)));
    endtask

    // One mask frame, measure pass then search pass; bottom runs of random
    // length per column, random texture above them.
    task automatic run_frame(input bit same_mask);
        int unsigned w;
        int unsigned h;
        int unsigned len;
        bit mask [];
        bit p;
        w    = eff_w;
        h    = eff_h;
        mask = new[w * h];
        for (int c = 0; c < w; c++) begin
            len = $urandom_range(h);
            for (int r = 0; r < h; r++)
                mask[r * w + c] = (r < len) ? 1'b1 : (r == len) ? 1'b0 : 1'($urandom_range(1));
        end
        for (int i = 0; i < w * h; i++) push_pixel(MODE_MEASURE, mask[i]);
        for (int i = 0; i < w * h; i++) begin
            p = mask[i];
            if (!same_mask && $urandom_range(3) == 0) p = !p;
            push_pixel(MODE_SEARCH, p);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking, receiver stalls, activity count
    // ---------------------------------------------------------------
    task automatic report_word(input string what, input edge_word_t want, input edge_word_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at %0t: want row=%0d lf=%0d lx=%0d rf=%0d rx=%0d lb=%0d rb=%0d",
                     what, $time, want.row, want.left_found, want.left_x,
                     want.right_found, want.right_x, want.left_base, want.right_base);
            $display("    got row=%0d lf=%0d lx=%0d rf=%0d rx=%0d lb=%0d rb=%0d",
                     got.row, got.left_found, got.left_x,
                     got.right_found, got.right_x, got.left_base, got.right_base);
        end
    endtask

    always @(posedge aclk) begin : result_check
        edge_word_t got;
        edge_word_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (edge_words_due.size() == 0) begin
                report_word("unexpected word", '0, got);
            end else begin
                want = edge_words_due[0];
                edge_words_due.delete(0);
                if (got !== want) report_word("word mismatch", want, got);
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("lane_edge_point_finder: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic dir_step_t cfg_step(input logic [lepf_pkg::CFG_ADDR_W-1:0] addr,
                                           input logic [lepf_pkg::CFG_DATA_W-1:0] value);
        dir_step_t st;
        st       = '0;
        st.kind  = STEP_CFG;
        st.addr  = addr;
        st.value = value;
        return st;
    endfunction

    function automatic dir_step_t pix_step(input bit mode, input bit pix);
        dir_step_t st;
        st      = '0;
        st.kind = STEP_PIX;
        st.mode = mode;
        st.pix  = pix;
        return st;
    endfunction

    function automatic dir_step_t typed_step(input bit mode, input bit pix,
                                             input int row, input bit rf, input int rb);
        dir_step_t st;
        st                  = pix_step(mode, pix);
        st.kind             = STEP_PIX_TYPED;
        st.want.row         = 10'(row);
        st.want.right_found = rf;
        st.want.right_base  = 11'(rb);
        return st;
    endfunction

    initial begin : stimulus
        dir_step_t dir_steps [$];
        dir_step_t st;
        int goal;
        int sel;

        // width written as 1 runs at 2; height still at its reset value
        dir_steps = {dir_steps, cfg_step(lepf_pkg::REG_FRAME_WIDTH, 12'd1)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};
        dir_steps = {dir_steps, typed_step(MODE_SEARCH, 1'b0, 719, 1'b0, 0)};
        // falling step right of base 0 gives a right edge at column 0
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b1)};
        dir_steps = {dir_steps, typed_step(MODE_SEARCH, 1'b0, 718, 1'b1, 0)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};
        // height cut below the row count: row reads 0 and the frame wraps
        dir_steps = {dir_steps, cfg_step(lepf_pkg::REG_FRAME_HEIGHT, 12'd1)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};
        dir_steps = {dir_steps, typed_step(MODE_SEARCH, 1'b1, 0, 1'b0, 0)};
        dir_steps = {dir_steps, cfg_step(lepf_pkg::REG_FRAME_HEIGHT, 12'd0)};
        // smallest frame, measure then search
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b1)};
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b1)};
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b1)};
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b0)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b1)};
        dir_steps = {dir_steps, typed_step(MODE_SEARCH, 1'b0, 1, 1'b0, 1)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b1)};
        // pass switched inside a row
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b1)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b1)};
        dir_steps = {dir_steps, pix_step(MODE_MEASURE, 1'b0)};
        dir_steps = {dir_steps, pix_step(MODE_SEARCH, 1'b0)};

        src_idle_pct = 37;
        snk_idle_pct = 67;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_steps[i]) begin
            st = dir_steps[i];
            if (st.kind == STEP_CFG) begin
                write_reg(st.addr, st.value);
            end else begin
                push_pixel(st.mode, st.pix);
                if (st.kind == STEP_PIX_TYPED) edge_words_due[$] = st.want;
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 37;
                    snk_idle_pct = 67;
                end
                1: begin
                    src_idle_pct = 67;
                    snk_idle_pct = 37;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // tallest frame: a few narrow search rows read the clamped height
                write_reg(lepf_pkg::REG_FRAME_WIDTH, 12'd2);
                write_reg(lepf_pkg::REG_FRAME_HEIGHT, 12'd2);
                align_frame();
                write_reg(lepf_pkg::REG_FRAME_HEIGHT, 12'h7FF);
                repeat (16) push_pixel(MODE_SEARCH, 1'($urandom_range(1)));
                write_reg(lepf_pkg::REG_FRAME_HEIGHT, 12'd2);
                align_frame();
            end

            goal = pixels_sent + RANDOM_ITEMS / 3;
            while (pixels_sent < goal) begin
                if ($urandom_range(3) == 0) begin
                    write_reg(lepf_pkg::REG_FRAME_WIDTH, ($urandom_range(15) == 0) ?
                              12'($urandom_range(1)) : 12'($urandom_range(2, 12)));
                    write_reg(lepf_pkg::REG_FRAME_HEIGHT, ($urandom_range(15) == 0) ?
                              12'($urandom_range(1)) : 12'($urandom_range(2, 6)));
                end
                sel = $urandom_range(9);
                if (sel < 8) begin
                    align_frame();
                    run_frame($urandom_range(3) != 0);
                end else begin
                    // noise: random pass per word, row and frame left open
                    repeat ($urandom_range(1, 3 * eff_w))
                        push_pixel(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (edge_words_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && edge_words_due.size() == 0) begin
            $display("lane_edge_point_finder: match");
        end else begin
            $display("lane_edge_point_finder: mismatch");
        end
        $finish;
    end

endmodule
